[rtl/glrg_pkg.sv]
// Shared types and constants for the grained linear ramp generator.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package glrg_pkg;

  localparam int OPCODE_W = 2;
  localparam int DATA_W   = 32;
  localparam int RAMP_W   = 24;
  localparam int GRAIN_W  = 16;

  localparam logic [GRAIN_W-1:0] GRAIN_DEFAULT = 16'd20;

  typedef enum logic [OPCODE_W-1:0] {
    OP_GO     = 2'd0,
    OP_SET    = 2'd1,
    OP_CANCEL = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_FIN,
    ST_EMIT
  } state_t;

endpackage

[rtl/glrg_ifs.sv]
// Handshake channel interfaces: command input, result output and grain register write.
// Depends on glrg_pkg for the payload widths.
`timescale 1ns / 1ps

interface glrg_in_if import glrg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [DATA_W-1:0]   value_in;
  logic [RAMP_W-1:0]          ramp_ticks;

  modport source (output valid, opcode, value_in, ramp_ticks, input ready);
  modport sink   (input valid, opcode, value_in, ramp_ticks, output ready);
endinterface

interface glrg_out_if import glrg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   value_out;
  logic                       ramp_done;

  modport source (output valid, value_out, ramp_done, input ready);
  modport sink   (input valid, value_out, ramp_done, output ready);
endinterface

interface glrg_cfg_if import glrg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [GRAIN_W-1:0]         grain_ticks;

  modport source (output valid, grain_ticks, input ready);
  modport sink   (input valid, grain_ticks, output ready);
endinterface

[rtl/grained_linear_ramp_generator.sv]
// Grained linear ramp generator: tick clock, ramp state and a serial interpolation unit.
// Depends on glrg_pkg and the channel interfaces in glrg_ifs.sv.
//
//   channel | dir | payload                          | handshake
//   --------+-----+----------------------------------+-----------------
//   in_ch   | in  | opcode, value_in, ramp_ticks     | valid / ready
//   out_ch  | out | value_out, ramp_done             | valid / ready
//   cfg_ch  | in  | grain_ticks                      | valid / ready
//
// Set, cancel and ticks that emit nothing return straight to idle. Emitting items without
// interpolation pass through the emit state; items that interpolate pass through load,
// the one-bit-per-cycle multiply-divide loop in the step state, finish and emit.
// A result waits in the output register while the next beat is accepted; a new
// result waits until that register is free. Reset is synchronous.
// The grain register is always ready.
`timescale 1ns / 1ps

module grained_linear_ramp_generator import glrg_pkg::*; #(
  parameter int TIME_BITS  = 48,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  glrg_cfg_if.sink    cfg_ch,
  glrg_in_if.sink     in_ch,
  glrg_out_if.source  out_ch
);

  localparam int TB    = TIME_BITS;
  localparam int VB    = VALUE_BITS;
  localparam int CNT_W = $clog2(VB + 1);
  localparam int TW    = RAMP_W + 2;

  state_t state_r, state_nxt;

  logic [TB-1:0]     time_now_r, time_now_nxt;
  logic [TB-1:0]     start_time_r, start_time_nxt;
  logic [TB-1:0]     end_time_r, end_time_nxt;
  logic [VB-1:0]     start_lvl_r, start_lvl_nxt;
  logic [VB-1:0]     end_lvl_r, end_lvl_nxt;
  logic [RAMP_W-1:0] countdown_r, countdown_nxt;
  logic              active_r, active_nxt;
  logic [GRAIN_W-1:0] grain_r, grain_nxt;

  logic              pend_go_r, pend_go_nxt;
  logic [VB-1:0]     pend_lvl_r, pend_lvl_nxt;
  logic [RAMP_W-1:0] pend_len_r, pend_len_nxt;

  logic              byp_r, byp_nxt;
  logic              neg_r, neg_nxt;
  logic [VB-1:0]     mag_r, mag_nxt;
  logic [RAMP_W-1:0] a_r, a_nxt;
  logic [RAMP_W-1:0] b_r, b_nxt;
  logic [RAMP_W-1:0] rem_r, rem_nxt;
  logic [VB-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [VB-1:0]     res_lvl_r, res_lvl_nxt;
  logic              res_done_r, res_done_nxt;

  logic [DATA_W-1:0] out_val_r, out_val_nxt;
  logic              out_done_r, out_done_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              in_ready;
  logic              in_fire;
  op_t               in_op;
  logic [VB+DATA_W-1:0] in_ext;
  logic [VB-1:0]     lvl_in;
  logic [VB+DATA_W-1:0] res_ext;

  logic [TB-1:0]     time_inc;
  logic [TB-1:0]     tick_el;
  logic [TB-1:0]     span_full;
  logic [TB-1:0]     a_full;
  logic [RAMP_W-1:0] tick_rem;
  logic [RAMP_W-1:0] tick_wait;
  logic [RAMP_W-1:0] len_sel;
  logic [RAMP_W-1:0] go_wait;
  logic [RAMP_W-1:0] grain_ext;
  logic [TB-1:0]     go_end_time;

  logic [VB:0]       diff;
  logic [VB:0]       diff_neg;

  logic [RAMP_W-1:0] a_add;
  logic [TW-1:0]     t_sum;
  logic [TW-1:0]     b_one;
  logic [TW-1:0]     b_two;
  logic [TW-1:0]     t_sub1;
  logic [TW-1:0]     t_sub2;
  logic [VB-1:0]     quo_sh;
  logic [VB-1:0]     lvl_fin;

  assign in_ready       = (state_r == ST_IDLE);
  assign in_fire        = in_ch.valid && in_ready;
  assign in_ch.ready    = in_ready;
  assign in_op          = op_t'(in_ch.opcode);
  assign cfg_ch.ready   = 1'b1;

  // Input levels wider than 32 bits take the word as an unsigned pattern.
  assign in_ext  = {{VB{1'b0}}, in_ch.value_in};
  assign lvl_in  = in_ext[VB-1:0];
  assign res_ext = {{DATA_W{1'b0}}, res_lvl_r};

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_out = out_val_r;
  assign out_ch.ramp_done = out_done_r;

  // Time arithmetic for the tick path and the go path.
  assign grain_ext   = {{(RAMP_W-GRAIN_W){1'b0}}, grain_r};
  assign time_inc    = time_now_r + {{(TB-1){1'b0}}, 1'b1};
  assign span_full   = end_time_r - start_time_r;
  assign tick_el     = time_inc - start_time_r;
  assign a_full      = time_now_r - start_time_r;
  assign tick_rem    = span_full[RAMP_W-1:0] - tick_el[RAMP_W-1:0];
  assign tick_wait   = (tick_rem < grain_ext) ? tick_rem : grain_ext;
  assign len_sel     = (state_r == ST_FIN) ? pend_len_r : in_ch.ramp_ticks;
  assign go_wait     = (len_sel < grain_ext) ? len_sel : grain_ext;
  assign go_end_time = time_now_r + {{(TB-RAMP_W){1'b0}}, len_sel};

  assign diff     = {end_lvl_r[VB-1], end_lvl_r} - {start_lvl_r[VB-1], start_lvl_r};
  assign diff_neg = -diff;

  // One step of floor(mag * a / b), mag bits taken MSB first. The partial
  // remainder stays below b, so at most two subtractions of b are needed.
  assign a_add  = mag_r[VB-1] ? a_r : '0;
  assign t_sum  = {1'b0, rem_r, 1'b0} + {2'b00, a_add};
  assign b_one  = {2'b00, b_r};
  assign b_two  = {1'b0, b_r, 1'b0};
  assign t_sub1 = t_sum - b_one;
  assign t_sub2 = t_sum - b_two;
  assign quo_sh = {quo_r[VB-2:0], 1'b0};

  assign lvl_fin = byp_r ? end_lvl_r : (neg_r ? start_lvl_r - quo_r : start_lvl_r + quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_now_r  <= '0;
      start_time_r <= '0;
      end_time_r  <= '0;
      start_lvl_r <= '0;
      end_lvl_r   <= '0;
      countdown_r <= '0;
      active_r    <= 1'b0;
      grain_r     <= GRAIN_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_now_r  <= time_now_nxt;
      start_time_r <= start_time_nxt;
      end_time_r  <= end_time_nxt;
      start_lvl_r <= start_lvl_nxt;
      end_lvl_r   <= end_lvl_nxt;
      countdown_r <= countdown_nxt;
      active_r    <= active_nxt;
      grain_r     <= grain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_go_r  <= pend_go_nxt;
    pend_lvl_r <= pend_lvl_nxt;
    pend_len_r <= pend_len_nxt;
    byp_r      <= byp_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    res_lvl_r  <= res_lvl_nxt;
    res_done_r <= res_done_nxt;
    out_val_r  <= out_val_nxt;
    out_done_r <= out_done_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    time_now_nxt   = time_now_r;
    start_time_nxt = start_time_r;
    end_time_nxt   = end_time_r;
    start_lvl_nxt  = start_lvl_r;
    end_lvl_nxt    = end_lvl_r;
    countdown_nxt  = countdown_r;
    active_nxt     = active_r;
    grain_nxt      = grain_r;
    pend_go_nxt    = pend_go_r;
    pend_lvl_nxt   = pend_lvl_r;
    pend_len_nxt   = pend_len_r;
    byp_nxt        = byp_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    res_lvl_nxt    = res_lvl_r;
    res_done_nxt   = res_done_r;
    out_val_nxt    = out_val_r;
    out_done_nxt   = out_done_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    if (cfg_ch.valid) begin
      grain_nxt = (cfg_ch.grain_ticks == '0) ? GRAIN_DEFAULT : cfg_ch.grain_ticks;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          pend_lvl_nxt = lvl_in;
          pend_len_nxt = in_ch.ramp_ticks;
          unique case (in_op)
            OP_GO: begin
              if (in_ch.ramp_ticks == '0) begin
                start_lvl_nxt = lvl_in;
                end_lvl_nxt   = lvl_in;
                active_nxt    = 1'b0;
                countdown_nxt = '0;
                res_lvl_nxt   = lvl_in;
                res_done_nxt  = 1'b1;
                state_nxt     = ST_EMIT;
              end else if (active_r) begin
                // Retrigger: the new ramp starts from the level reached now.
                pend_go_nxt = 1'b1;
                state_nxt   = ST_LOAD;
              end else begin
                start_lvl_nxt  = end_lvl_r;
                end_lvl_nxt    = lvl_in;
                start_time_nxt = time_now_r;
                end_time_nxt   = go_end_time;
                active_nxt     = 1'b1;
                countdown_nxt  = go_wait;
                res_lvl_nxt    = end_lvl_r;
                res_done_nxt   = 1'b0;
                state_nxt      = ST_EMIT;
              end
            end
            OP_SET: begin
              start_lvl_nxt = lvl_in;
              end_lvl_nxt   = lvl_in;
              active_nxt    = 1'b0;
              countdown_nxt = '0;
            end
            OP_CANCEL: begin
              end_lvl_nxt   = start_lvl_r;
              active_nxt    = 1'b0;
              countdown_nxt = '0;
            end
            OP_TICK: begin
              time_now_nxt = time_inc;
              if (active_r) begin
                if (countdown_r > RAMP_W'(1)) begin
                  countdown_nxt = countdown_r - RAMP_W'(1);
                end else if (tick_el >= span_full) begin
                  active_nxt    = 1'b0;
                  countdown_nxt = '0;
                  res_lvl_nxt   = end_lvl_r;
                  res_done_nxt  = 1'b1;
                  state_nxt     = ST_EMIT;
                end else begin
                  countdown_nxt = tick_wait;
                  pend_go_nxt   = 1'b0;
                  state_nxt     = ST_LOAD;
                end
              end
            end
          endcase
        end
      end
      ST_LOAD: begin
        byp_nxt   = (span_full == '0) || (a_full >= span_full);
        neg_nxt   = diff[VB];
        mag_nxt   = diff[VB] ? diff_neg[VB-1:0] : diff[VB-1:0];
        a_nxt     = a_full[RAMP_W-1:0];
        b_nxt     = span_full[RAMP_W-1:0];
        rem_nxt   = '0;
        quo_nxt   = '0;
        cnt_nxt   = CNT_W'(VB);
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (t_sum >= b_two) begin
          rem_nxt = t_sub2[RAMP_W-1:0];
          quo_nxt = quo_sh + VB'(2);
        end else if (t_sum >= b_one) begin
          rem_nxt = t_sub1[RAMP_W-1:0];
          quo_nxt = quo_sh + VB'(1);
        end else begin
          rem_nxt = t_sum[RAMP_W-1:0];
          quo_nxt = quo_sh;
        end
        mag_nxt = {mag_r[VB-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (pend_go_r) begin
          start_lvl_nxt  = lvl_fin;
          end_lvl_nxt    = pend_lvl_r;
          start_time_nxt = time_now_r;
          end_time_nxt   = go_end_time;
          active_nxt     = 1'b1;
          countdown_nxt  = go_wait;
        end
        res_lvl_nxt  = lvl_fin;
        res_done_nxt = 1'b0;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_val_nxt   = res_ext[DATA_W-1:0];
          out_done_nxt  = res_done_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/glrg_checker.sv]
// Port-level checker for the grained linear ramp generator, bound to the top level.
// Depends on glrg_pkg for opcode names.
`timescale 1ns / 1ps

module glrg_checker import glrg_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [OPCODE_W-1:0] in_opcode,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DATA_W-1:0]   out_value,
  input logic                out_done
);

  // A result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_done))
    else $error("stalled result beat changed its payload");

  // Every go produces a result, so the input side closes right after it.
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_GO) |=> !in_ready)
    else $error("input stayed open after a go beat");

  // Set and cancel finish in the cycle they are taken.
  a_silent_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && ((in_opcode == OP_SET) || (in_opcode == OP_CANCEL))
    |=> in_ready)
    else $error("input closed after a set or cancel beat");

  // No result is offered straight out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind grained_linear_ramp_generator glrg_checker u_glrg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value_out),
  .out_done  (out_ch.ramp_done)
);
